// ===== design/vlvc_pkg.sv =====
package vlvc_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_ALT    = 2'd0,
    OP_MARKER = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } vlvc_op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_DERIV_GAIN = 3'd1,
    REG_CENTRE_U   = 3'd2,
    REG_CENTRE_V   = 3'd3,
    REG_FOCAL_U    = 3'd4,
    REG_FOCAL_V    = 3'd5,
    REG_HOLD_ALT   = 3'd6,
    REG_LOST_LIMIT = 3'd7
  } vlvc_reg_t;

  // Serial lane widths
  localparam int MCAND_W  = 30;               // largest multiplicand: deriv_gain*15625
  localparam int MPLIER_W = 16;               // largest multiplier: |error delta|
  localparam int ACC_W    = MCAND_W + MPLIER_W;
  localparam int DEN_W    = 22;               // 4*dt_us
  localparam int QUOT_W   = 25;               // widest quotient before clipping
  localparam int DSH_W    = DEN_W + QUOT_W;
  localparam int QCNT_W   = $clog2(QUOT_W + 1);

  // Quotient widths of the two divisions
  localparam logic [QCNT_W-1:0] MK_QBITS = QCNT_W'(15);
  localparam logic [QCNT_W-1:0] D_QBITS  = QCNT_W'(QUOT_W);

  // Command into one serial lane
  typedef struct packed {
    logic                    start_mul;
    logic                    start_div;
    logic [MCAND_W-1:0]      mcand;
    logic [MPLIER_W-1:0]     mplier;
    logic [DEN_W-1:0]        den;
    logic [QCNT_W-1:0]       qbits;
  } vlvc_lane_cmd_t;

  // Status out of one serial lane
  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [ACC_W-1:0]        acc;
    logic [QUOT_W-1:0]       quot;
  } vlvc_lane_st_t;

endpackage

// ===== design/vlvc_serial_lane.sv =====
module vlvc_serial_lane import vlvc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  vlvc_lane_cmd_t cmd,
  output vlvc_lane_st_t  st
);

  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV} ustate_t;

  ustate_t             ustate;
  logic [QCNT_W-1:0]   cnt;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    mc;
  logic [MPLIER_W-1:0] mp;
  logic [DSH_W-1:0]    dsh;
  logic [QUOT_W-1:0]   quot;
  logic                done;
  logic                clip;

  logic [DSH_W-1:0]    den_top;
  logic [QUOT_W-1:0]   qmask;
  logic                rem_ge;

  // Divisor aligned to the top quotient bit, and the clip value
  assign den_top = DSH_W'(cmd.den) << cmd.qbits;
  assign qmask   = QUOT_W'(({{QUOT_W{1'b0}}, 1'b1} << cmd.qbits) - 1'b1);
  assign rem_ge  = DSH_W'(acc) >= dsh;

  // Shift-add multiply, one multiplier bit a cycle; restoring divide, one
  // quotient bit a cycle, remainder kept in the accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      case (ustate)
        U_IDLE: begin
          done <= 1'b0;
          if (cmd.start_mul) begin
            acc    <= '0;
            mc     <= ACC_W'(cmd.mcand);
            mp     <= cmd.mplier;
            cnt    <= QCNT_W'(MPLIER_W);
            ustate <= U_MUL;
          end else if (cmd.start_div) begin
            // a quotient that would not fit is clipped to all ones; the divide still steps through every quotient bit
            clip   <= (DSH_W'(acc) >= den_top);
            dsh    <= den_top >> 1;
            quot   <= '0;
            cnt    <= cmd.qbits;
            ustate <= U_DIV;
          end
        end
        U_MUL: begin
          if (mp[0]) begin
            acc <= acc + mc;
          end
          mc   <= mc << 1;
          mp   <= mp >> 1;
          cnt  <= cnt - 1'b1;
          done <= (cnt == QCNT_W'(1));
          if (cnt == QCNT_W'(1)) begin
            ustate <= U_IDLE;
          end
        end
        U_DIV: begin
          if (clip) begin
            quot <= qmask;
          end else if (rem_ge) begin
            acc  <= acc - ACC_W'(dsh);
            quot <= {quot[QUOT_W-2:0], 1'b1};
          end else begin
            quot <= {quot[QUOT_W-2:0], 1'b0};
          end
          dsh  <= dsh >> 1;
          cnt  <= cnt - 1'b1;
          done <= (cnt == QCNT_W'(1));
          if (cnt == QCNT_W'(1)) begin
            ustate <= U_IDLE;
          end
        end
        default: begin
          ustate <= U_IDLE;
          done   <= 1'b0;
        end
      endcase
    end
  end

  assign st.busy = (ustate != U_IDLE);
  assign st.done = done;
  assign st.acc  = acc;
  assign st.quot = quot;

endmodule

// ===== design/visual_landing_velocity_controller.sv =====
// Visual landing velocity controller.
// Input stream: s_tuser selects the item kind (altitude sample, marker pixel,
// control tick); s_tdata carries range, marker pixel, tick interval and the
// offboard flag. Every accepted input transaction yields exactly one output
// transaction: x/y/z velocity and the hold flag in m_tdata, m_tuser high
// only for a control tick.
// Configuration: cfg_we writes cfg_data into register cfg_idx;
// write only while no item is in flight.
// Sequencing: one item at a time. Altitude samples, lost markers, unused kinds
// and ticks while holding go from accept straight to S_DONE, which loads them
// into the output register. A found marker runs a serial multiply, then a serial
// divide by the focal length; a control tick runs two serial multiplies and a
// divide by four times the tick interval, in two lanes, x and y.
// The output register holds a result until m_tready; the next input is taken
// once the previous result has been loaded there, so a stalled receiver
// stops input once one further item waits in S_DONE.
// Reset (rst, synchronous) clears the sequencer, controller state and lanes,
// loads default calibration and drops m_tvalid.
module visual_landing_velocity_controller import vlvc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // range_mm[12:0], marker_u[22:13], marker_v[32:23], dt_us[52:33],
  // offboard[53], zero fill
  input  logic [55:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // vel_x[12:0], vel_y[25:13], vel_z[33:26], holding[34], zero fill
  output logic [39:0] m_tdata,
  // cmd_valid[0]
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [15:0] cfg_data
);

  localparam int P_LSB = 16;
  localparam int P_W   = 24;
  localparam int SUM_W = 27;
  localparam int VEL_W = 13;
  localparam logic [12:0]        ALT_MIN_MM   = 13'd280;
  localparam logic [12:0]        LOW_ALT_MM   = 13'd1000;
  localparam logic [7:0]         LOST_MAX     = 8'd255;
  localparam logic signed [7:0]  DESCEND_MMPS = -8'sd100;
  localparam logic signed [SUM_W-1:0] VEL_MAX = SUM_W'(4000);

  typedef enum logic [2:0] {
    S_IDLE, S_MK_MUL, S_MK_DIV, S_TK_PMUL, S_TK_DMUL, S_TK_DDIV, S_DONE
  } state_t;

  // Configuration
  logic [15:0] prop_gain;
  logic [15:0] deriv_gain;
  logic [9:0]  centre_u;
  logic [9:0]  centre_v;
  logic [11:0] focal_u;
  logic [11:0] focal_v;
  logic [12:0] hold_alt;
  logic [7:0]  lost_limit;

  // Controller state
  state_t             state;
  logic               init_seen;
  logic               hold_flag;
  logic [12:0]        altitude;
  logic signed [15:0] error_x;
  logic signed [15:0] error_y;
  logic signed [15:0] prev_error_x;
  logic signed [15:0] prev_error_y;
  logic [7:0]         lost_count;

  // Per-item work registers
  logic                    neg_ax, neg_ay, neg_dx, neg_dy;
  logic [MPLIER_W-1:0]     dmag_x, dmag_y;
  logic [P_W-1:0]          p_x, p_y;
  logic [19:0]             dt_q;
  logic signed [VEL_W-1:0] res_vx, res_vy;
  logic signed [7:0]       res_vz;
  logic                    res_cmd;

  vlvc_lane_cmd_t cmd_x, cmd_y;
  vlvc_lane_st_t  st_x, st_y;
  logic           lane_done;

  // Input fields
  vlvc_op_t    in_op;
  logic [12:0] in_range;
  logic [9:0]  in_mu, in_mv;
  logic [19:0] in_dt;
  logic        in_offb;

  // Derived values
  logic               mk_valid;
  logic signed [10:0] du, dv;
  logic [9:0]         umag, vmag;
  logic [7:0]         lost_inc;
  logic [15:0]        ex_mag, ey_mag;
  logic signed [16:0] dx, dy;
  logic [15:0]        dx_mag, dy_mag;
  logic [14:0]        alt3;
  logic [18:0]        ex10, ey10;
  logic               descend;
  logic [24:0]        geff;
  logic [29:0]        dg_k;
  logic [19:0]        dt_nz;
  logic [DEN_W-1:0]   dt_den;
  logic [DEN_W-1:0]   fu_den, fv_den;
  logic [14:0]        qx, qy;

  assign in_op    = vlvc_op_t'(s_tuser);
  assign in_range = s_tdata[12:0];
  assign in_mu    = s_tdata[22:13];
  assign in_mv    = s_tdata[32:23];
  assign in_dt    = s_tdata[52:33];
  assign in_offb  = s_tdata[53];

  assign s_tready  = (state == S_IDLE);
  assign lane_done = st_x.done;

  // Marker pixel offsets from the principal point
  always_comb begin
    mk_valid = (in_mu != '0) && (in_mv != '0);
    du       = $signed({1'b0, in_mu}) - $signed({1'b0, centre_u});
    dv       = $signed({1'b0, in_mv}) - $signed({1'b0, centre_v});
    umag     = du[10] ? 10'(-du) : du[9:0];
    vmag     = dv[10] ? 10'(-dv) : dv[9:0];
    lost_inc = (lost_count == LOST_MAX) ? LOST_MAX : lost_count + 1'b1;
    fu_den   = DEN_W'((focal_u == '0) ? 12'd1 : focal_u);
    fv_den   = DEN_W'((focal_v == '0) ? 12'd1 : focal_v);
    qx       = st_x.quot[14:0];
    qy       = st_y.quot[14:0];
  end

  // Tick operands: magnitudes, descend test, effective gains
  always_comb begin
    ex_mag  = error_x[15] ? 16'(-error_x) : 16'(error_x);
    ey_mag  = error_y[15] ? 16'(-error_y) : 16'(error_y);
    dx      = {error_x[15], error_x} - {prev_error_x[15], prev_error_x};
    dy      = {error_y[15], error_y} - {prev_error_y[15], prev_error_y};
    dx_mag  = dx[16] ? 16'(-dx) : dx[15:0];
    dy_mag  = dy[16] ? 16'(-dy) : dy[15:0];
    alt3    = 15'(altitude) + 15'({altitude, 1'b0});
    ex10    = 19'({ex_mag, 3'b000}) + 19'({ex_mag, 1'b0});
    ey10    = 19'({ey_mag, 3'b000}) + 19'({ey_mag, 1'b0});
    descend = (ex10 < 19'(alt3)) && (ey10 < 19'(alt3));
    // low altitude boost 333/256, else gain/256 lifted to the same scale
    if (altitude < LOW_ALT_MM) begin
      geff = 25'({prop_gain, 8'b0}) + 25'({prop_gain, 6'b0}) + 25'({prop_gain, 3'b0})
           + 25'({prop_gain, 2'b0}) + 25'(prop_gain);
    end else begin
      geff = 25'({prop_gain, 8'b0});
    end
    // 1e6/256 = 15625/4: numerator gain*15625, divisor 4*dt
    dg_k   = 30'({deriv_gain, 14'b0}) - 30'({deriv_gain, 9'b0}) - 30'({deriv_gain, 8'b0})
           + 30'({deriv_gain, 3'b0}) + 30'(deriv_gain);
    dt_nz  = (dt_q == '0) ? 20'd1 : dt_q;
    dt_den = {dt_nz, 2'b00};
  end

  // Signed P + D, saturated to the velocity limit
  function automatic logic signed [VEL_W-1:0] pd_sum(
    input logic [P_W-1:0]    p,
    input logic              neg_p,
    input logic [QUOT_W-1:0] d,
    input logic              neg_d
  );
    logic signed [SUM_W-1:0] sp;
    logic signed [SUM_W-1:0] sd;
    logic signed [SUM_W-1:0] s;
    sp = SUM_W'(p);
    sd = SUM_W'(d);
    if (neg_p) sp = -sp;
    if (neg_d) sd = -sd;
    s = sp + sd;
    if (s > VEL_MAX) s = VEL_MAX;
    else if (s < -VEL_MAX) s = -VEL_MAX;
    return VEL_W'(s);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= 16'd0;
      deriv_gain <= 16'd0;
      centre_u   <= 10'd319;
      centre_v   <= 10'd220;
      focal_u    <= 12'd487;
      focal_v    <= 12'd488;
      hold_alt   <= 13'd1800;
      lost_limit <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        REG_CENTRE_U:   centre_u   <= cfg_data[9:0];
        REG_CENTRE_V:   centre_v   <= cfg_data[9:0];
        REG_FOCAL_U:    focal_u    <= cfg_data[11:0];
        REG_FOCAL_V:    focal_v    <= cfg_data[11:0];
        REG_HOLD_ALT:   hold_alt   <= cfg_data[12:0];
        REG_LOST_LIMIT: lost_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      cmd_x        <= '0;
      cmd_y        <= '0;
      init_seen    <= 1'b0;
      hold_flag    <= 1'b0;
      altitude     <= '0;
      error_x      <= '0;
      error_y      <= '0;
      prev_error_x <= '0;
      prev_error_y <= '0;
      lost_count   <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_vx  <= '0;
            res_vy  <= '0;
            res_vz  <= (in_op == OP_TICK && !hold_flag && descend) ? DESCEND_MMPS : 8'sd0;
            res_cmd <= (in_op == OP_TICK);
            case (in_op)
              OP_ALT: begin
                if (in_range > ALT_MIN_MM) begin
                  if (!init_seen) init_seen <= 1'b1;
                  else            altitude  <= in_range;
                end
                state <= S_DONE;
              end
              OP_MARKER: begin
                if (mk_valid) begin
                  lost_count      <= '0;
                  neg_ax          <= du[10];
                  neg_ay          <= dv[10];
                  cmd_x.start_mul <= 1'b1;
                  cmd_x.mcand     <= MCAND_W'(altitude);
                  cmd_x.mplier    <= MPLIER_W'(umag);
                  cmd_y.start_mul <= 1'b1;
                  cmd_y.mcand     <= MCAND_W'(altitude);
                  cmd_y.mplier    <= MPLIER_W'(vmag);
                  state           <= S_MK_MUL;
                end else begin
                  // marker lost
                  if (in_offb && (lost_inc > lost_limit)) begin
                    if (altitude > hold_alt) begin
                      hold_flag <= 1'b1;
                    end else begin
                      error_x      <= '0;
                      error_y      <= '0;
                      prev_error_x <= '0;
                      prev_error_y <= '0;
                    end
                    lost_count <= '0;
                  end else begin
                    lost_count <= lost_inc;
                  end
                  state <= S_DONE;
                end
              end
              OP_TICK: begin
                if (hold_flag) begin
                  state <= S_DONE;
                end else begin
                  prev_error_x    <= error_x;
                  prev_error_y    <= error_y;
                  neg_ax          <= error_x[15];
                  neg_ay          <= error_y[15];
                  neg_dx          <= dx[16];
                  neg_dy          <= dy[16];
                  dmag_x          <= dx_mag;
                  dmag_y          <= dy_mag;
                  dt_q            <= in_dt;
                  cmd_x.start_mul <= 1'b1;
                  cmd_x.mcand     <= MCAND_W'(geff);
                  cmd_x.mplier    <= ex_mag;
                  cmd_y.start_mul <= 1'b1;
                  cmd_y.mcand     <= MCAND_W'(geff);
                  cmd_y.mplier    <= ey_mag;
                  state           <= S_TK_PMUL;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        // altitude*|offset| done, divide by focal length
        S_MK_MUL: begin
          if (lane_done) begin
            cmd_x.start_div <= 1'b1;
            cmd_x.den       <= fu_den;
            cmd_x.qbits     <= MK_QBITS;
            cmd_y.start_div <= 1'b1;
            cmd_y.den       <= fv_den;
            cmd_y.qbits     <= MK_QBITS;
            state           <= S_MK_DIV;
          end else begin
            cmd_x.start_mul <= 1'b0;
            cmd_y.start_mul <= 1'b0;
          end
        end
        // x error is negated image offset
        S_MK_DIV: begin
          if (lane_done) begin
            error_x <= neg_ax ? $signed({1'b0, qx}) : -$signed({1'b0, qx});
            error_y <= neg_ay ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            state   <= S_DONE;
          end else begin
            cmd_x.start_div <= 1'b0;
            cmd_y.start_div <= 1'b0;
          end
        end
        // P term ready, start derivative numerator
        S_TK_PMUL: begin
          if (lane_done) begin
            p_x             <= st_x.acc[P_LSB +: P_W];
            p_y             <= st_y.acc[P_LSB +: P_W];
            cmd_x.start_mul <= 1'b1;
            cmd_x.mcand     <= dg_k;
            cmd_x.mplier    <= dmag_x;
            cmd_y.start_mul <= 1'b1;
            cmd_y.mcand     <= dg_k;
            cmd_y.mplier    <= dmag_y;
            state           <= S_TK_DMUL;
          end else begin
            cmd_x.start_mul <= 1'b0;
            cmd_y.start_mul <= 1'b0;
          end
        end
        S_TK_DMUL: begin
          if (lane_done) begin
            cmd_x.start_div <= 1'b1;
            cmd_x.den       <= dt_den;
            cmd_x.qbits     <= D_QBITS;
            cmd_y.start_div <= 1'b1;
            cmd_y.den       <= dt_den;
            cmd_y.qbits     <= D_QBITS;
            state           <= S_TK_DDIV;
          end else begin
            cmd_x.start_mul <= 1'b0;
            cmd_y.start_mul <= 1'b0;
          end
        end
        S_TK_DDIV: begin
          if (lane_done) begin
            res_vx <= pd_sum(p_x, neg_ax, st_x.quot, neg_dx);
            res_vy <= pd_sum(p_y, neg_ay, st_y.quot, neg_dy);
            state  <= S_DONE;
          end else begin
            cmd_x.start_div <= 1'b0;
            cmd_y.start_div <= 1'b0;
          end
        end
        // load output register once it is free
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, hold_flag, res_vz, res_vy, res_vx};
            m_tuser  <= res_cmd;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vlvc_serial_lane u_lane_x (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_x),
    .st  (st_x)
  );

  vlvc_serial_lane u_lane_y (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_y),
    .st  (st_y)
  );

`ifndef ASSERT_OFF
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    st_x.done == st_y.done)
    else $error("x and y lanes out of step");

  a_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!st_x.busy && !st_y.busy))
    else $error("input taken while a lane is busy");

  a_hold_sticky: assert property (@(posedge clk) disable iff (rst)
    hold_flag |=> hold_flag)
    else $error("hold flag cleared without reset");

  a_nontick_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[33:0] == '0))
    else $error("non-tick result carries velocity");
`endif

endmodule

// ===== verif/tb_visual_landing_velocity_controller.sv =====
module tb_visual_landing_velocity_controller;
  import vlvc_pkg::*;

  localparam int ALT_FLOOR_MM  = 280;
  localparam int ERR_LIMIT     = 32767;
  localparam int VEL_LIMIT     = 4000;
  localparam int DESCEND_MMPS  = -100;
  localparam int LOW_ALT_MM    = 1000;
  localparam int LOW_ALT_BOOST = 333;
  localparam int LOST_CAP      = 255;
  localparam int CYCLE_LIMIT   = 1000000;

  // One sensor / tick item as it travels on the input stream
  typedef struct packed {
    vlvc_op_t    op;
    logic [12:0] range_mm;
    logic [9:0]  marker_u;
    logic [9:0]  marker_v;
    logic [19:0] dt_us;
    logic        offboard;
  } sensor_item_t;

  // One velocity command as it leaves the block
  typedef struct packed {
    logic signed [12:0] vel_x;
    logic signed [12:0] vel_y;
    logic signed [7:0]  vel_z;
    logic               holding;
    logic               cmd_valid;
  } velocity_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  // Calibration and gains as the block should hold them (reset values)
  int cfg_prop       = 0;
  int cfg_deriv      = 0;
  int cfg_centre_u   = 319;
  int cfg_centre_v   = 220;
  int cfg_focal_u    = 487;
  int cfg_focal_v    = 488;
  int cfg_hold_alt   = 1800;
  int cfg_lost_limit = 10;

  // Controller state mirror
  bit alt_init_seen = 1'b0;
  bit hold_active   = 1'b0;
  int init_alt      = 0;
  int cur_alt       = 0;
  int err_x         = 0;
  int err_y         = 0;
  int prev_err_x    = 0;
  int prev_err_y    = 0;
  int lost_cnt      = 0;

  velocity_cmd_t cmd_expected[$];
  int fail_count  = 0;
  int cycle_count = 0;
  int gap_pct     = 35;
  int stall_pct   = 35;

  visual_landing_velocity_controller uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Run-length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Ground offset of the marker on one axis, mm
  function automatic int marker_error(int pix, int centre, int focal);
    longint num;
    longint f;
    f = (focal == 0) ? 1 : focal;
    num = longint'(cur_alt) * (pix - centre);
    return int'(clip(num / f, ERR_LIMIT));
  endfunction

  // PD law for one axis; P gets the low-altitude boost
  function automatic int axis_velocity(int e, int pe, int dt);
    longint p;
    longint d;
    longint den;
    den = longint'((dt == 0) ? 1 : dt) * 256;
    if (cur_alt < LOW_ALT_MM)
      p = (longint'(e) * cfg_prop * LOW_ALT_BOOST) / 65536;
    else
      p = (longint'(e) * cfg_prop) / 256;
    d = (longint'(e - pe) * cfg_deriv * 1000000) / den;
    return int'(clip(p + d, VEL_LIMIT));
  endfunction

  // Advance the state mirror by one item and return the command it yields
  function automatic velocity_cmd_t predict_command(sensor_item_t it);
    velocity_cmd_t r;
    int lim;
    int ax;
    int ay;
    r = '0;
    case (it.op)
      OP_ALT: begin
        if (it.range_mm > ALT_FLOOR_MM) begin
          if (!alt_init_seen) begin
            alt_init_seen = 1'b1;
            init_alt = it.range_mm;
          end else begin
            cur_alt = it.range_mm;
          end
        end
      end
      OP_MARKER: begin
        if (it.marker_u != 0 && it.marker_v != 0) begin
          err_x = -marker_error(it.marker_u, cfg_centre_u, cfg_focal_u);
          err_y = marker_error(it.marker_v, cfg_centre_v, cfg_focal_v);
          lost_cnt = 0;
        end else begin
          if (lost_cnt < LOST_CAP) lost_cnt++;
          // lost-marker reaction: hold when high, else forget the errors
          if (it.offboard && lost_cnt > cfg_lost_limit) begin
            if (cur_alt > cfg_hold_alt) begin
              hold_active = 1'b1;
            end else begin
              err_x = 0;
              err_y = 0;
              prev_err_x = 0;
              prev_err_y = 0;
            end
            lost_cnt = 0;
          end
        end
      end
      OP_TICK: begin
        r.cmd_valid = 1'b1;
        if (!hold_active) begin
          lim = 3 * cur_alt;
          ax = (err_x < 0) ? -err_x : err_x;
          ay = (err_y < 0) ? -err_y : err_y;
          if (10 * ax < lim && 10 * ay < lim) r.vel_z = 8'(DESCEND_MMPS);
          r.vel_x = 13'(axis_velocity(err_x, prev_err_x, it.dt_us));
          r.vel_y = 13'(axis_velocity(err_y, prev_err_y, it.dt_us));
          prev_err_x = err_x;
          prev_err_y = err_y;
        end
      end
      default: ;
    endcase
    r.holding = hold_active;
    return r;
  endfunction

  task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Output checker
  always @(posedge clk) begin
    velocity_cmd_t got;
    velocity_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.vel_x     = m_tdata[12:0];
      got.vel_y     = m_tdata[25:13];
      got.vel_z     = m_tdata[33:26];
      got.holding   = m_tdata[34];
      got.cmd_valid = m_tuser;
      if (cmd_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected output transaction: tdata %h tuser %b", m_tdata, m_tuser);
      end else begin
        want = cmd_expected.pop_front();
        check_field("vel_x", want.vel_x, got.vel_x);
        check_field("vel_y", want.vel_y, got.vel_y);
        check_field("vel_z", want.vel_z, got.vel_z);
        check_field("holding", want.holding, got.holding);
        check_field("cmd_valid", want.cmd_valid, got.cmd_valid);
      end
    end
  end

  function automatic sensor_item_t make_item(vlvc_op_t op, int range_mm, int mu, int mv,
                                             int dt, bit offb);
    sensor_item_t it;
    it.op       = op;
    it.range_mm = 13'(range_mm);
    it.marker_u = 10'(mu);
    it.marker_v = 10'(mv);
    it.dt_us    = 20'(dt);
    it.offboard = offb;
    return it;
  endfunction

  // Push one input transaction, with random leading gaps
  task automatic send_item(sensor_item_t it);
    velocity_cmd_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {2'b00, it.offboard, it.dt_us, it.marker_v, it.marker_u, it.range_mm};
    do @(posedge clk); while (!s_tready);
    want = predict_command(it);
    cmd_expected.push_back(want);
  endtask

  // Stop sending and wait until every command has come out
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (cmd_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(vlvc_reg_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_PROP_GAIN:  cfg_prop       = value;
      REG_DERIV_GAIN: cfg_deriv      = value;
      REG_CENTRE_U:   cfg_centre_u   = value[9:0];
      REG_CENTRE_V:   cfg_centre_v   = value[9:0];
      REG_FOCAL_U:    cfg_focal_u    = value[11:0];
      REG_FOCAL_V:    cfg_focal_v    = value[11:0];
      REG_HOLD_ALT:   cfg_hold_alt   = value[12:0];
      REG_LOST_LIMIT: cfg_lost_limit = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // New random calibration; hold threshold given by the caller
  task automatic shuffle_config(int hold_alt, int limit_max);
    settle();
    write_reg(REG_PROP_GAIN,
              ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1024)));
    write_reg(REG_DERIV_GAIN,
              ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 512)));
    write_reg(REG_CENTRE_U, 16'($urandom_range(0, 1023)));
    write_reg(REG_CENTRE_V, 16'($urandom_range(0, 1023)));
    write_reg(REG_FOCAL_U,
              ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 4095))
                                          : 16'($urandom_range(300, 800)));
    write_reg(REG_FOCAL_V,
              ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 4095))
                                          : 16'($urandom_range(300, 800)));
    write_reg(REG_HOLD_ALT, 16'(hold_alt));
    write_reg(REG_LOST_LIMIT, 16'($urandom_range(0, limit_max)));
  endtask

  // Mostly plausible flight traffic, with noise in every field
  task automatic random_item(int lost_pct);
    sensor_item_t it;
    int pick;
    int off;
    int u;
    int v;
    it.op       = OP_NONE;
    it.range_mm = 13'($urandom);
    it.marker_u = 10'($urandom);
    it.marker_v = 10'($urandom);
    it.dt_us    = 20'($urandom);
    it.offboard = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      it.op = OP_ALT;
      if ($urandom_range(0, 9) < 8) it.range_mm = 13'($urandom_range(281, 6000));
    end else if (pick < 55) begin
      it.op = OP_MARKER;
      if ($urandom_range(0, 99) < lost_pct) begin
        case ($urandom_range(0, 2))
          0: it.marker_u = '0;
          1: it.marker_v = '0;
          default: begin
            it.marker_u = '0;
            it.marker_v = '0;
          end
        endcase
      end else if ($urandom_range(0, 9) < 8) begin
        // marker seen near the image centre
        off = $urandom_range(0, 300);
        u = cfg_centre_u + off - 150;
        off = $urandom_range(0, 300);
        v = cfg_centre_v + off - 150;
        if (u < 1) u = 1;
        if (u > 1023) u = 1023;
        if (v < 1) v = 1;
        if (v > 1023) v = 1023;
        it.marker_u = 10'(u);
        it.marker_v = 10'(v);
      end
    end else if (pick < 95) begin
      it.op = OP_TICK;
      if ($urandom_range(0, 9) < 8) it.dt_us = 20'($urandom_range(2000, 100000));
    end
    send_item(it);
  endtask

  // Field extremes and every item kind, at reset calibration and at extreme calibration
  task automatic test_directed_extremes();
    send_item(make_item(OP_NONE, 8191, 1023, 1023, 20'hFFFFF, 1'b1));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ALT, 280, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ALT, 281, 0, 0, 0, 1'b0));
    send_item(make_item(OP_ALT, 8191, 0, 0, 0, 1'b0));
    send_item(make_item(OP_MARKER, 0, 1, 1, 0, 1'b0));
    send_item(make_item(OP_MARKER, 0, 1023, 1023, 0, 1'b0));
    send_item(make_item(OP_MARKER, 0, 0, 1023, 0, 1'b0));
    send_item(make_item(OP_MARKER, 0, 1023, 0, 0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 20'hFFFFF, 1'b0));
    settle();
    write_reg(REG_PROP_GAIN, 16'hFFFF);
    write_reg(REG_DERIV_GAIN, 16'hFFFF);
    write_reg(REG_CENTRE_U, 16'd0);
    write_reg(REG_CENTRE_V, 16'd1023);
    write_reg(REG_FOCAL_U, 16'd0);
    write_reg(REG_FOCAL_V, 16'd4095);
    write_reg(REG_HOLD_ALT, 16'd8191);
    write_reg(REG_LOST_LIMIT, 16'd0);
    // errors clip, then velocities clip
    send_item(make_item(OP_MARKER, 0, 1023, 1, 0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 1, 1'b0));
    // lost with limit zero at max altitude: errors cleared, no hold
    send_item(make_item(OP_MARKER, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_TICK, 0, 0, 0, 1000, 1'b0));
    // low altitude boost
    send_item(make_item(OP_ALT, 500, 0, 0, 0, 1'b0));
    send_item(make_item(OP_MARKER, 0, 5, 1000, 0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 40000, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 40000, 1'b0));
  endtask

  // Lost counter sticks at its cap; a cap-sized limit never reacts
  task automatic test_lost_saturation();
    settle();
    write_reg(REG_LOST_LIMIT, 16'd255);
    for (int i = 0; i < 260; i++)
      send_item(make_item(OP_MARKER, $urandom, 0, (i % 2) ? 0 : $urandom_range(1, 1023),
                          $urandom, 1'($urandom)));
    settle();
    write_reg(REG_LOST_LIMIT, 16'd254);
    send_item(make_item(OP_MARKER, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_MARKER, 0, 400, 300, 0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 20000, 1'b0));
  endtask

  // Random traffic under one random calibration; hold kept out of reach
  task automatic test_random_phase(int n, int idle);
    shuffle_config(8191, 15);
    gap_pct   = idle;
    stall_pct = idle;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) settle();
      random_item(15);
    end
    gap_pct   = 35;
    stall_pct = 35;
  endtask

  // Enter position hold high above the pad, then keep going
  task automatic test_hold_entry();
    shuffle_config($urandom_range(0, 1) ? 0 : $urandom_range(300, 2000), 3);
    send_item(make_item(OP_ALT, 6000, 0, 0, 0, 1'b0));
    send_item(make_item(OP_TICK, 0, 0, 0, 30000, 1'b0));
    for (int i = 0; i <= cfg_lost_limit; i++)
      send_item(make_item(OP_MARKER, 0, 0, 0, 0, 1'b1));
    send_item(make_item(OP_TICK, 0, 0, 0, 30000, 1'b0));
    for (int i = 0; i < 100; i++) random_item(40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_lost_saturation();
    for (int p = 0; p < 5; p++) test_random_phase(280, (p == 2) ? 0 : 35);
    test_hold_entry();
    settle();
    repeat (70) @(posedge clk);
    if (fail_count == 0 && cmd_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/vlvc_pkg.sv
design/vlvc_serial_lane.sv
design/visual_landing_velocity_controller.sv
verif/tb_visual_landing_velocity_controller.sv
